>>> hdl/cpeq_pkg.sv
// Package for the class priority eviction queues.
// Holds command and status codes, the result struct and parameter defaults.
// No dependencies.
package cpeq_pkg;

   localparam int DefCostClasses    = 2;
   localparam int DefPriorityLevels = 4;
   localparam int DefQueueDepth     = 16;

   localparam int BlockIdWidth = 16;
   localparam int SeqWidth     = 32;
   localparam int EntryWidth   = BlockIdWidth + SeqWidth;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_POP     = 1'b1;

   typedef enum logic [2:0] {
      ST_ENQUEUED = 3'd0,
      ST_INVALID  = 3'd1,
      ST_FULL     = 3'd2,
      ST_POPPED   = 3'd3,
      ST_EMPTY    = 3'd4
   } cpeq_status_type;

   typedef struct packed {
      cpeq_status_type status;
      logic            cost_class;
      logic [1:0]      priority_level;
   } cpeq_res_type;

endpackage

>>> hdl/class_priority_eviction_queues.sv
// Top level of the class priority eviction queues.
// Depends on cpeq_pkg, cpeq_ctrl and cpeq_ram.
//
// The block keeps COST_CLASSES x PRIORITY_LEVELS FIFO queues of eviction
// candidates, each QUEUE_DEPTH deep, in one entry RAM. Every transaction on
// the req_ channel is either an enqueue or a pop and yields exactly one
// transaction on the rsp_ channel, in order. An enqueue with an out-of-range
// class or level is dropped with status invalid; one to a full queue is dropped
// with status full. A pop returns the head of the first non-empty queue,
// cheapest class first and lowest level first, or reports empty.
// The queue is picked and the pointers updated in the cycle of acceptance; the
// RAM read of a popped entry takes the next cycle, and the result is then held
// in the output register. A result goes through stage one and then the output
// register, and one request is accepted every cycle while req_stall is low.
// Reset empties all queues. When the receiver holds rsp_stall, the result
// stays on the rsp_ ports, one more request fills the internal stage, and then
// req_stall goes high until the output is taken.
module class_priority_eviction_queues import cpeq_pkg::*; #(
   parameter int COST_CLASSES    = DefCostClasses,
   parameter int PRIORITY_LEVELS = DefPriorityLevels,
   parameter int QUEUE_DEPTH     = DefQueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_cmd,
   input  logic [1:0]              req_cost_class,
   input  logic [2:0]              req_priority_level,
   input  logic [BlockIdWidth-1:0] req_block_id,
   input  logic [SeqWidth-1:0]     req_seq_number,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic                    rsp_out_cost_class,
   output logic [1:0]              rsp_out_priority_level,
   output logic [BlockIdWidth-1:0] rsp_out_block_id,
   output logic [SeqWidth-1:0]     rsp_out_seq_number
);

   localparam int NQ = COST_CLASSES * PRIORITY_LEVELS;
   localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int AW = QW + PW;

   logic                  req_go;
   cpeq_res_type          ctrl_res;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_addr;
   logic [EntryWidth-1:0] ram_wr_data;
   logic [EntryWidth-1:0] ram_rd_data;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   cpeq_res_type          s1_res_ff;
   cpeq_res_type          s1_res_in;
   logic                  s1_move;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   cpeq_res_type          rsp_res_ff;
   logic [EntryWidth-1:0] rsp_data_ff;
   logic [EntryWidth-1:0] rsp_data_in;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_go    = req_valid && !req_stall;

   cpeq_ctrl #(
      .COST_CLASSES    (COST_CLASSES),
      .PRIORITY_LEVELS (PRIORITY_LEVELS),
      .QUEUE_DEPTH     (QUEUE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .go             (req_go),
      .cmd            (req_cmd),
      .cost_class     (req_cost_class),
      .priority_level (req_priority_level),
      .block_id       (req_block_id),
      .seq_number     (req_seq_number),
      .res            (ctrl_res),
      .ram_wr_en      (ram_wr_en),
      .ram_rd_en      (ram_rd_en),
      .ram_addr       (ram_addr),
      .ram_wr_data    (ram_wr_data)
   );

   // Read data only changes on an accepted pop, so it holds while stage one
   // waits for the output register.
   cpeq_ram #(
      .WIDTH (EntryWidth),
      .DEPTH (2 ** AW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   assign s1_valid_in  = req_go || (s1_valid_ff && !s1_move);
   assign s1_res_in    = req_go ? ctrl_res : s1_res_ff;
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = (s1_res_ff.status == ST_POPPED) ? ram_rd_data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_res_ff <= s1_res_in;
      if (s1_move) begin
         rsp_res_ff  <= s1_res_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_res_ff.status;
   assign rsp_out_cost_class     = rsp_res_ff.cost_class;
   assign rsp_out_priority_level = rsp_res_ff.priority_level;
   assign rsp_out_block_id       = rsp_data_ff[EntryWidth-1:SeqWidth];
   assign rsp_out_seq_number     = rsp_data_ff[SeqWidth-1:0];

endmodule

>>> hdl/cpeq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the candidate entry store. No dependencies.
module cpeq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cpeq_ctrl.sv
// Queue bookkeeping: head, tail and fill count per queue, the enqueue check
// and the strict-priority pop select. Depends on cpeq_pkg.
module cpeq_ctrl import cpeq_pkg::*; #(
   parameter int COST_CLASSES    = DefCostClasses,
   parameter int PRIORITY_LEVELS = DefPriorityLevels,
   parameter int QUEUE_DEPTH     = DefQueueDepth,
   localparam int NQ  = COST_CLASSES * PRIORITY_LEVELS,
   localparam int QW  = (NQ > 1) ? $clog2(NQ) : 1,
   localparam int PW  = $clog2(QUEUE_DEPTH),
   localparam int AW  = QW + PW
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic                    cmd,
   input  logic [1:0]              cost_class,
   input  logic [2:0]              priority_level,
   input  logic [BlockIdWidth-1:0] block_id,
   input  logic [SeqWidth-1:0]     seq_number,
   output cpeq_res_type            res,
   output logic                    ram_wr_en,
   output logic                    ram_rd_en,
   output logic [AW-1:0]           ram_addr,
   output logic [EntryWidth-1:0]   ram_wr_data
);

   localparam int CNW = $clog2(QUEUE_DEPTH + 1);

   logic [PW-1:0]  head_ff  [NQ];
   logic [PW-1:0]  head_in  [NQ];
   logic [PW-1:0]  tail_ff  [NQ];
   logic [PW-1:0]  tail_in  [NQ];
   logic [CNW-1:0] count_ff [NQ];
   logic [CNW-1:0] count_in [NQ];

   logic          enq_bad;
   logic          enq_full;
   logic [QW-1:0] enq_q;
   logic          pop_found;
   logic [QW-1:0] pop_q;
   logic          pop_cls;
   logic [1:0]    pop_pri;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] ptr);
      return (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   assign enq_bad  = (32'(cost_class) >= COST_CLASSES) ||
                     (32'(priority_level) >= PRIORITY_LEVELS);
   assign enq_q    = QW'(32'(cost_class) * PRIORITY_LEVELS + 32'(priority_level));
   assign enq_full = (count_ff[enq_q] == CNW'(QUEUE_DEPTH));
   assign ram_wr_data = {block_id, seq_number};

   // Cheapest class first, then lowest priority level within the class.
   always_comb begin
      pop_found = 1'b0;
      pop_q     = '0;
      pop_cls   = 1'b0;
      pop_pri   = '0;
      for (int c = 0; c < COST_CLASSES; c++) begin
         for (int p = 0; p < PRIORITY_LEVELS; p++) begin
            if (!pop_found && (count_ff[c * PRIORITY_LEVELS + p] != '0)) begin
               pop_found = 1'b1;
               pop_q     = QW'(c * PRIORITY_LEVELS + p);
               pop_cls   = 1'(c);
               pop_pri   = 2'(p);
            end
         end
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      res       = '{status: ST_EMPTY, cost_class: 1'b0, priority_level: 2'd0};
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      ram_addr  = {pop_q, head_ff[pop_q]};
      if (cmd == CMD_ENQUEUE) begin
         ram_addr = {enq_q, tail_ff[enq_q]};
         priority if (enq_bad) begin
            res.status = ST_INVALID;
         end else if (enq_full) begin
            res.status = ST_FULL;
         end else begin
            res.status = ST_ENQUEUED;
            if (go) begin
               ram_wr_en       = 1'b1;
               tail_in[enq_q]  = advance(tail_ff[enq_q]);
               count_in[enq_q] = count_ff[enq_q] + CNW'(1);
            end
         end
      end else if (pop_found) begin
         res.status         = ST_POPPED;
         res.cost_class     = pop_cls;
         res.priority_level = pop_pri;
         if (go) begin
            ram_rd_en       = 1'b1;
            head_in[pop_q]  = advance(head_ff[pop_q]);
            count_in[pop_q] = count_ff[pop_q] - CNW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> tb/cpeq_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the class priority eviction queues testbench.
// Holds a bank-of-FIFOs predictor and the queue of expected responses.
// Depends on cpeq_pkg.
package cpeq_sb_pkg;
   import cpeq_pkg::*;

   localparam int NumClasses = DefCostClasses;
   localparam int NumLevels  = DefPriorityLevels;
   localparam int QueueDepth = DefQueueDepth;
   localparam int NumQueues  = NumClasses * NumLevels;
   localparam int ExpSlots   = 64;

   typedef struct packed {
      logic                    cmd;
      logic [1:0]              cost_class;
      logic [2:0]              priority_level;
      logic [BlockIdWidth-1:0] block_id;
      logic [SeqWidth-1:0]     seq_number;
   } cand_req_type;

   typedef struct packed {
      cpeq_status_type         status;
      logic                    cost_class;
      logic [1:0]              priority_level;
      logic [BlockIdWidth-1:0] block_id;
      logic [SeqWidth-1:0]     seq_number;
   } cand_rsp_type;

   class eviction_scoreboard;
      logic [EntryWidth-1:0] cand_mem [NumQueues][QueueDepth];
      int                    head_idx [NumQueues];
      int                    tail_idx [NumQueues];
      int                    occupancy [NumQueues];
      // Expected responses kept in a ring; the DUT never holds more than a few.
      cand_rsp_type          expected_rsps [ExpSlots];
      int                    exp_wr;
      int                    exp_rd;
      int                    mismatches;

      function new();
         mismatches = 0;
         exp_wr     = 0;
         exp_rd     = 0;
         for (int q = 0; q < NumQueues; q++) begin
            head_idx[q]  = 0;
            tail_idx[q]  = 0;
            occupancy[q] = 0;
         end
      endfunction

      function int pending();
         return exp_wr - exp_rd;
      endfunction

      // Updates the queue bank for one accepted request and records its response.
      function void note_request(cand_req_type r);
         cand_rsp_type rsp;
         int           q;
         bit           found;
         rsp   = '0;
         found = 1'b0;
         if (r.cmd == CMD_ENQUEUE) begin
            if (r.cost_class >= NumClasses || r.priority_level >= NumLevels) begin
               rsp.status = ST_INVALID;
            end else begin
               q = r.cost_class * NumLevels + r.priority_level;
               if (occupancy[q] >= QueueDepth) begin
                  rsp.status = ST_FULL;
               end else begin
                  cand_mem[q][tail_idx[q]] = {r.block_id, r.seq_number};
                  tail_idx[q] = (tail_idx[q] + 1) % QueueDepth;
                  occupancy[q]++;
                  rsp.status = ST_ENQUEUED;
               end
            end
         end else begin
            rsp.status = ST_EMPTY;
            // Queue index order is cheapest class first, lowest level first.
            for (int i = 0; i < NumQueues; i++) begin
               if (!found && occupancy[i] != 0) begin
                  found = 1'b1;
                  rsp.status         = ST_POPPED;
                  rsp.cost_class     = 1'(i / NumLevels);
                  rsp.priority_level = 2'(i % NumLevels);
                  {rsp.block_id, rsp.seq_number} = cand_mem[i][head_idx[i]];
                  head_idx[i] = (head_idx[i] + 1) % QueueDepth;
                  occupancy[i]--;
               end
            end
         end
         expected_rsps[exp_wr % ExpSlots] = rsp;
         exp_wr++;
      endfunction

      function void check_response(cand_rsp_type act);
         cand_rsp_type exp_rsp;
         if (pending() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response with nothing outstanding: status %0d blk %h seq %h",
                        act.status, act.block_id, act.seq_number);
            return;
         end
         exp_rsp = expected_rsps[exp_rd % ExpSlots];
         exp_rd++;
         if (act.status !== exp_rsp.status || act.cost_class !== exp_rsp.cost_class ||
             act.priority_level !== exp_rsp.priority_level ||
             act.block_id !== exp_rsp.block_id || act.seq_number !== exp_rsp.seq_number)
         begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: exp st %0d cls %0d pri %0d blk %h seq %h",
                        exp_rsp.status, exp_rsp.cost_class, exp_rsp.priority_level,
                        exp_rsp.block_id, exp_rsp.seq_number);
               $display("          got st %0d cls %0d pri %0d blk %h seq %h",
                        act.status, act.cost_class, act.priority_level,
                        act.block_id, act.seq_number);
            end
         end
      endfunction
   endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the class priority eviction queues testbench: clock, reset, request
// driver, response monitor and back-pressure. Depends on cpeq_pkg, cpeq_sb_pkg
// and the class_priority_eviction_queues RTL.
module tb_top;
   import cpeq_pkg::*;
   import cpeq_sb_pkg::*;

   localparam int RandomItems = 1030;
   localparam int CycleLimit  = 200000;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;
   localparam int MODE_NOISE = 3;

   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_cmd = CMD_ENQUEUE;
   logic [1:0]              req_cost_class = '0;
   logic [2:0]              req_priority_level = '0;
   logic [BlockIdWidth-1:0] req_block_id = '0;
   logic [SeqWidth-1:0]     req_seq_number = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [2:0]              rsp_status;
   logic                    rsp_out_cost_class;
   logic [1:0]              rsp_out_priority_level;
   logic [BlockIdWidth-1:0] rsp_out_block_id;
   logic [SeqWidth-1:0]     rsp_out_seq_number;

   int                 cycle_count = 0;
   eviction_scoreboard sb = new();

   class_priority_eviction_queues DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_cmd                (req_cmd),
      .req_cost_class         (req_cost_class),
      .req_priority_level     (req_priority_level),
      .req_block_id           (req_block_id),
      .req_seq_number         (req_seq_number),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_out_cost_class     (rsp_out_cost_class),
      .rsp_out_priority_level (rsp_out_priority_level),
      .rsp_out_block_id       (rsp_out_block_id),
      .rsp_out_seq_number     (rsp_out_seq_number)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("tb_top NOT OK");
      $finish;
   end

   // Back-pressure changes character whenever stall_left runs out.
   int stall_mode = STALL_NONE;
   int stall_left = 0;
   int stall_period = 4;

   always @(posedge clock) begin
      logic stall_next;
      stall_next = 1'b0;
      if (!reset) begin
         if (stall_left == 0) begin
            stall_mode   = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_left   = $urandom_range(16, 160);
            stall_period = $urandom_range(2, 7);
         end
         stall_left--;
         case (stall_mode)
            STALL_LIGHT:    stall_next = ($urandom_range(0, 99) < 20);
            STALL_HEAVY:    stall_next = ($urandom_range(0, 99) < 70);
            STALL_PERIODIC: stall_next = ((cycle_count % stall_period) == 0);
            default:        stall_next = 1'b0;
         endcase
      end
      rsp_stall <= stall_next;
   end

   always @(posedge clock) begin
      cand_rsp_type act;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         act.status         = cpeq_status_type'(rsp_status);
         act.cost_class     = rsp_out_cost_class;
         act.priority_level = rsp_out_priority_level;
         act.block_id       = rsp_out_block_id;
         act.seq_number     = rsp_out_seq_number;
         sb.check_response(act);
      end
   end

   // Drives one transaction and returns at the edge where it is accepted.
   task automatic send_req(input cand_req_type r);
      req_valid          <= 1'b1;
      req_cmd            <= r.cmd;
      req_cost_class     <= r.cost_class;
      req_priority_level <= r.priority_level;
      req_block_id       <= r.block_id;
      req_seq_number     <= r.seq_number;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_request(r);
   endtask

   function automatic cand_req_type make_req(input logic cmd, input int cls, input int pri,
                                             input logic [BlockIdWidth-1:0] blk,
                                             input logic [SeqWidth-1:0] seq);
      cand_req_type r;
      r.cmd            = cmd;
      r.cost_class     = 2'(cls);
      r.priority_level = 3'(pri);
      r.block_id       = blk;
      r.seq_number     = seq;
      return r;
   endfunction

   function automatic cand_req_type random_req(input int mode, input int focus);
      cand_req_type r;
      int           roll;
      int           bad_pct;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  r.cmd = (roll < 85) ? CMD_ENQUEUE : CMD_POP;
         MODE_DRAIN: r.cmd = (roll < 80) ? CMD_POP : CMD_ENQUEUE;
         MODE_NOISE: r.cmd = (roll < 70) ? CMD_ENQUEUE : CMD_POP;
         default:    r.cmd = (roll < 50) ? CMD_ENQUEUE : CMD_POP;
      endcase
      bad_pct = (mode == MODE_NOISE) ? 50 : 8;
      r.block_id   = BlockIdWidth'($urandom);
      r.seq_number = $urandom;
      if ($urandom_range(0, 99) < bad_pct) begin
         if ($urandom_range(0, 1) == 0) begin
            r.cost_class     = 2'($urandom_range(2, 3));
            r.priority_level = 3'($urandom_range(0, 7));
         end else begin
            r.cost_class     = 2'($urandom_range(0, 1));
            r.priority_level = 3'($urandom_range(4, 7));
         end
      end else if (mode == MODE_FILL && $urandom_range(0, 99) < 60) begin
         // Concentrating on one queue drives it to full and through the wrap.
         r.cost_class     = 2'(focus / NumLevels);
         r.priority_level = 3'(focus % NumLevels);
      end else begin
         r.cost_class     = 2'($urandom_range(0, NumClasses - 1));
         r.priority_level = 3'($urandom_range(0, NumLevels - 1));
      end
      return r;
   endfunction

   initial begin
      int sent;
      int mode;
      int focus;
      int phase_left;
      int burst;
      int gap;
      sent       = 0;
      mode       = MODE_FILL;
      focus      = 0;
      phase_left = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty bank, out-of-range codes, field extremes, one full queue.
      send_req(make_req(CMD_POP, 3, 7, '1, '1));
      send_req(make_req(CMD_ENQUEUE, 2, 0, 16'h1234, 32'h1));
      send_req(make_req(CMD_ENQUEUE, 3, 7, 16'h5678, 32'h2));
      send_req(make_req(CMD_ENQUEUE, 1, 4, 16'h9abc, 32'h3));
      send_req(make_req(CMD_ENQUEUE, 1, 3, '1, '1));
      send_req(make_req(CMD_ENQUEUE, 0, 0, '0, '0));
      for (int i = 0; i <= QueueDepth; i++)
         send_req(make_req(CMD_ENQUEUE, 0, 1, BlockIdWidth'(16'ha000 + i), $urandom));
      send_req(make_req(CMD_POP, 0, 0, '0, '0));
      send_req(make_req(CMD_POP, 3, 7, '1, '1));
      send_req(make_req(CMD_POP, 1, 2, BlockIdWidth'($urandom), $urandom));

      while (sent < RandomItems) begin
         if (phase_left <= 0) begin
            mode       = $urandom_range(MODE_FILL, MODE_NOISE);
            // Noise phases are made rarer so most traffic reaches the queues.
            if (mode == MODE_NOISE && $urandom_range(0, 1) == 0)
               mode = MODE_MIXED;
            focus      = $urandom_range(0, NumQueues - 1);
            phase_left = $urandom_range(30, 110);
         end
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst; i++) begin
            send_req(random_req(mode, focus));
            sent++;
            phase_left--;
         end
         gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

>>> class_priority_eviction_queues.f
hdl/cpeq_pkg.sv
hdl/cpeq_ram.sv
hdl/cpeq_ctrl.sv
hdl/class_priority_eviction_queues.sv
tb/cpeq_sb_pkg.sv
tb/tb_top.sv
